// ===== rtl/plcfe_pkg.sv =====
// shared constants, types and helpers for the command frame encoder
package plcfe_pkg;

    localparam logic [3:0] KIND_D      = 4'd0;
    localparam logic [3:0] KIND_X      = 4'd1;
    localparam logic [3:0] KIND_YOUT   = 4'd2;
    localparam logic [3:0] KIND_YPULSE = 4'd3;
    localparam logic [3:0] KIND_S      = 4'd4;
    localparam logic [3:0] KIND_T      = 4'd5;
    localparam logic [3:0] KIND_M      = 4'd6;
    localparam logic [3:0] KIND_C16    = 4'd7;
    localparam logic [3:0] KIND_C32    = 4'd8;
    localparam logic [3:0] KIND_CRST   = 4'd9;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_READ = 8'h30;
    localparam logic [7:0] CH_WRITE = 8'h31;
    localparam logic [7:0] CH_ERR  = 8'h00;

    localparam logic [15:0] BASE_D      = 16'h1000;
    localparam logic [15:0] BASE_D_SPEC = 16'h0E00;
    localparam logic [15:0] BASE_X      = 16'h0080;
    localparam logic [15:0] BASE_YOUT   = 16'h00A0;
    localparam logic [15:0] BASE_YPULSE = 16'h02A0;
    localparam logic [15:0] BASE_T      = 16'h0800;
    localparam logic [15:0] BASE_M      = 16'h0100;
    localparam logic [15:0] BASE_M_SPEC = 16'h01E0;
    localparam logic [15:0] BASE_C16    = 16'h0A00;
    localparam logic [15:0] BASE_C32    = 16'h0C00;
    localparam logic [15:0] BASE_CRST   = 16'h03C0;

    localparam logic [15:0] OCT_MAX  = 16'd7777;
    localparam logic [15:0] RECIP_10 = 16'd52429;

    localparam logic [4:0] XIN_LIMIT [4] = '{5'd6, 5'd8, 5'd12, 5'd16};

    typedef struct packed {
        logic        done;
        logic [1:0]  status;
        logic [15:0] addr;
        logic [2:0]  cnt;
    } map_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_STX,
        ST_CMD,
        ST_ADDR,
        ST_CNT,
        ST_DATA,
        ST_ETX,
        ST_SUM,
        ST_ERR
    } enc_state_t;

    function automatic logic [7:0] hexch(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = {4'h3, v};
        end
        else
        begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

// ===== rtl/plcfe_if.sv =====
// request and frame word channel interfaces
interface plcfe_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  device_kind;
    logic [15:0] device_number;
    logic [31:0] write_data;

    modport source(output valid, mode, device_kind, device_number, write_data, input ready);
    modport sink(input valid, mode, device_kind, device_number, write_data, output ready);
endinterface

interface plcfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;
    logic [3:0] expected_reply_length;

    modport source(output valid, frame_byte, last_byte, status, expected_reply_length,
                   input ready);
    modport sink(input valid, frame_byte, last_byte, status, expected_reply_length,
                 output ready);
endinterface

// ===== rtl/plcfe_map.sv =====
// device address mapper with a digit-serial octal decoder
module plcfe_map (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [3:0]         kind,
    input  logic [15:0]        number,
    input  logic [1:0]         model,
    output plcfe_pkg::map_res_t res
);
    import plcfe_pkg::*;

    logic        busy_reg;
    logic        fin_reg;
    logic [1:0]  step_reg;
    logic [12:0] n_reg;
    logic [11:0] k_reg;
    logic        bad_reg;
    logic [3:0]  kind_reg;
    logic [15:0] num_reg;

    logic [28:0] prod;
    logic [9:0]  quot;
    logic [12:0] quot_x10;
    logic [12:0] diff;
    logic [3:0]  digit;
    logic [15:0] off_8000;
    logic [15:0] off_200;

    assign prod     = {16'b0, n_reg} * {13'b0, RECIP_10};
    assign quot     = prod[28:19];
    assign quot_x10 = {quot, 3'b0} + {2'b0, quot, 1'b0};
    assign diff     = n_reg - quot_x10;
    assign digit    = diff[3:0];
    assign off_8000 = num_reg - 16'd8000;
    assign off_200  = num_reg - 16'd200;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else
        begin
            fin_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= number[12:0];
            k_reg    <= 12'd0;
            bad_reg  <= (number > OCT_MAX);
            kind_reg <= kind;
            num_reg  <= number;
        end
        else if (busy_reg)
        begin
            n_reg <= {3'b0, quot};
            k_reg <= {digit[2:0], k_reg[11:3]};
            if (digit > 4'd7)
            begin
                bad_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        res.done   = fin_reg;
        res.status = STAT_OK;
        res.addr   = 16'd0;
        res.cnt    = 3'd1;
        unique case (kind_reg) inside
            KIND_D:
            begin
                res.cnt = 3'd2;
                if (num_reg <= 16'd255 || (num_reg >= 16'd1000 && num_reg <= 16'd2499))
                begin
                    res.addr = BASE_D + {num_reg[14:0], 1'b0};
                end
                else if (num_reg >= 16'd8000 && num_reg <= 16'd8255)
                begin
                    res.addr = BASE_D_SPEC + {off_8000[14:0], 1'b0};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_X:
            begin
                if (bad_reg || k_reg >= {7'b0, XIN_LIMIT[model]})
                begin
                    res.status = STAT_BAD;
                end
                else
                begin
                    res.addr = BASE_X + {7'b0, k_reg[11:3]};
                end
            end
            KIND_YOUT, KIND_YPULSE:
            begin
                if (bad_reg)
                begin
                    res.status = STAT_BAD;
                end
                else
                begin
                    res.addr = ((kind_reg == KIND_YPULSE) ? BASE_YPULSE : BASE_YOUT)
                             + {7'b0, k_reg[11:3]};
                end
            end
            KIND_S:
            begin
                if (num_reg < 16'd128)
                begin
                    res.addr = {3'b0, num_reg[15:3]};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_T:
            begin
                res.cnt = 3'd2;
                if (num_reg <= 16'd63)
                begin
                    res.addr = BASE_T + {num_reg[14:0], 1'b0};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_M:
            begin
                if (num_reg < 16'd512)
                begin
                    res.addr = BASE_M + {3'b0, num_reg[15:3]};
                end
                else if (num_reg >= 16'd8000 && num_reg <= 16'd8255)
                begin
                    res.addr = BASE_M_SPEC + {3'b0, off_8000[15:3]};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_C16:
            begin
                res.cnt = 3'd2;
                if (num_reg < 16'd32)
                begin
                    res.addr = BASE_C16 + {num_reg[14:0], 1'b0};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_C32:
            begin
                res.cnt = 3'd4;
                if (num_reg > 16'd200 && num_reg <= 16'd255)
                begin
                    res.addr = BASE_C32 + {off_200[13:0], 2'b0};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_CRST:
            begin
                if (num_reg <= 16'd255)
                begin
                    res.addr = BASE_CRST + {3'b0, num_reg[15:3]};
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            default:
            begin
                res.status = STAT_BAD;
            end
        endcase
    end

endmodule

// ===== rtl/plc_device_command_frame_encoder.sv =====
// ascii hex command frame encoder top level
// the first frame word is presented once the address mapper has finished with the request
// a frame is 11 to 19 words, one word per cycle while the sink keeps up
// a new request is taken only after the last word of the previous frame (or its error word)
// request throughput is set by the four-step decimal digit unit and the byte sequencer
// reset clears control state and sets the model register to 0
module plc_device_command_frame_encoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    plcfe_in_if.sink          req,
    plcfe_out_if.source       frm
);
    import plcfe_pkg::*;

    enc_state_t  state_reg, state_next;
    logic [1:0]  plc_model_reg;
    logic        mode_reg;
    logic [31:0] data_reg, data_next;
    logic [15:0] addr_reg, addr_next;
    logic [2:0]  cnt_reg;
    logic [1:0]  err_stat_reg;
    logic [2:0]  dig_reg, dig_next;
    logic [7:0]  sum_reg, sum_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [1:0]  out_stat_reg;
    logic [3:0]  out_erl_reg;

    logic        accept;
    logic        load;
    logic        emit;
    logic [7:0]  byte_v;
    logic        last_v;
    logic [1:0]  stat_v;
    logic [3:0]  erl_v;
    logic [3:0]  nib_data;
    logic        last_data;
    map_res_t    mres;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign load      = !out_valid_reg || frm.ready;
    assign nib_data  = dig_reg[0] ? data_reg[3:0] : data_reg[7:4];
    assign last_data = ({1'b0, dig_reg} == ({cnt_reg, 1'b0} - 4'd1));

    assign frm.valid                 = out_valid_reg;
    assign frm.frame_byte            = out_byte_reg;
    assign frm.last_byte             = out_last_reg;
    assign frm.status                = out_stat_reg;
    assign frm.expected_reply_length = out_erl_reg;

    plcfe_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .kind   (req.device_kind),
        .number (req.device_number),
        .model  (plc_model_reg),
        .res    (mres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plc_model_reg <= 2'd0;
            out_valid_reg <= 1'b0;
            dig_reg       <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            dig_reg   <= dig_next;
            if (cfg_wr_en)
            begin
                plc_model_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        addr_reg <= addr_next;
        if (accept)
        begin
            mode_reg <= req.mode;
            data_reg <= req.write_data;
        end
        else
        begin
            data_reg <= data_next;
        end
        if (state_reg == ST_MAP && mres.done)
        begin
            cnt_reg      <= mres.cnt;
            err_stat_reg <= mres.status;
        end
        if (emit)
        begin
            out_byte_reg <= byte_v;
            out_last_reg <= last_v;
            out_stat_reg <= stat_v;
            out_erl_reg  <= erl_v;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        byte_v     = CH_ERR;
        last_v     = 1'b0;
        stat_v     = STAT_OK;
        erl_v      = mode_reg ? 4'd0 : ({cnt_reg, 1'b0} + 4'd4);
        dig_next   = dig_reg;
        sum_next   = sum_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (mres.done)
                begin
                    addr_next  = mres.addr;
                    dig_next   = 3'd0;
                    state_next = (mres.status == STAT_OK) ? ST_STX : ST_ERR;
                end
            end
            ST_STX:
            begin
                byte_v = CH_STX;
                if (load)
                begin
                    emit       = 1'b1;
                    sum_next   = 8'd0;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                byte_v = mode_reg ? CH_WRITE : CH_READ;
                if (load)
                begin
                    emit       = 1'b1;
                    sum_next   = sum_reg + byte_v;
                    dig_next   = 3'd0;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                byte_v = hexch(addr_reg[15:12]);
                if (load)
                begin
                    emit      = 1'b1;
                    sum_next  = sum_reg + byte_v;
                    addr_next = {addr_reg[11:0], 4'h0};
                    if (dig_reg == 3'd3)
                    begin
                        dig_next   = 3'd0;
                        state_next = ST_CNT;
                    end
                    else
                    begin
                        dig_next = dig_reg + 3'd1;
                    end
                end
            end
            ST_CNT:
            begin
                byte_v = dig_reg[0] ? hexch({1'b0, cnt_reg}) : hexch(4'h0);
                if (load)
                begin
                    emit     = 1'b1;
                    sum_next = sum_reg + byte_v;
                    if (dig_reg[0])
                    begin
                        dig_next   = 3'd0;
                        state_next = mode_reg ? ST_DATA : ST_ETX;
                    end
                    else
                    begin
                        dig_next = dig_reg + 3'd1;
                    end
                end
            end
            ST_DATA:
            begin
                byte_v = hexch(nib_data);
                if (load)
                begin
                    emit     = 1'b1;
                    sum_next = sum_reg + byte_v;
                    if (dig_reg[0])
                    begin
                        data_next = {8'h00, data_reg[31:8]};
                    end
                    if (last_data)
                    begin
                        dig_next   = 3'd0;
                        state_next = ST_ETX;
                    end
                    else
                    begin
                        dig_next = dig_reg + 3'd1;
                    end
                end
            end
            ST_ETX:
            begin
                byte_v = CH_ETX;
                if (load)
                begin
                    emit       = 1'b1;
                    sum_next   = sum_reg + byte_v;
                    dig_next   = 3'd0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                byte_v = dig_reg[0] ? hexch(sum_reg[3:0]) : hexch(sum_reg[7:4]);
                last_v = dig_reg[0];
                if (load)
                begin
                    emit = 1'b1;
                    if (dig_reg[0])
                    begin
                        dig_next   = 3'd0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_next = dig_reg + 3'd1;
                    end
                end
            end
            ST_ERR:
            begin
                byte_v = CH_ERR;
                last_v = 1'b1;
                stat_v = err_stat_reg;
                erl_v  = 4'd0;
                if (load)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/plcfe_checker.sv =====
// port-level assertions for the command frame encoder and their binding
module plcfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       frm_valid,
    input logic       frm_ready,
    input logic [7:0] frame_byte,
    input logic       last_byte,
    input logic [1:0] status,
    input logic [3:0] expected_reply_length
);
    import plcfe_pkg::*;

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && !frm_ready |=> frm_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("stalled frame word changed");

    // error result is a single zero word with no reply length
    assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && status != STAT_OK |->
            last_byte && frame_byte == CH_ERR && expected_reply_length == 4'd0)
        else $error("malformed error word");

    // frame start is never the last word and never an error
    assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frame_byte == CH_STX |-> status == STAT_OK && !last_byte)
        else $error("bad frame start word");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind plc_device_command_frame_encoder plcfe_checker u_plcfe_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (req.valid),
    .req_ready             (req.ready),
    .frm_valid             (frm.valid),
    .frm_ready             (frm.ready),
    .frame_byte            (frm.frame_byte),
    .last_byte             (frm.last_byte),
    .status                (frm.status),
    .expected_reply_length (frm.expected_reply_length)
);

// ===== sim/plcfe_frame_checker.sv =====
// frame word predictor and checker for the command frame encoder
module plcfe_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    plcfe_in_if         req,
    plcfe_out_if        frm,
    output int unsigned outstanding,
    output int          failures
);
    import plcfe_pkg::*;

    localparam logic [15:0] D_BASE       = 16'h1000;
    localparam logic [15:0] D_SPEC_BASE  = 16'h0E00;
    localparam logic [15:0] X_BASE       = 16'h0080;
    localparam logic [15:0] YOUT_BASE    = 16'h00A0;
    localparam logic [15:0] YPULSE_BASE  = 16'h02A0;
    localparam logic [15:0] T_BASE       = 16'h0800;
    localparam logic [15:0] M_BASE       = 16'h0100;
    localparam logic [15:0] M_SPEC_BASE  = 16'h01E0;
    localparam logic [15:0] C16_BASE     = 16'h0A00;
    localparam logic [15:0] C32_BASE     = 16'h0C00;
    localparam logic [15:0] CRST_BASE    = 16'h03C0;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [1:0] status;
        logic [3:0] reply_len;
    } frame_word_t;

    frame_word_t expected_words[$];
    logic [1:0]  model_sel;
    int          errors_seen = 0;

    function automatic int coil_limit(input logic [1:0] model);
        case (model)
            2'd0: return 6;
            2'd1: return 8;
            2'd2: return 12;
            default: return 16;
        endcase
    endfunction

    function automatic logic [7:0] ascii_hex(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + {4'h0, v};
        end
        return 8'h41 + {4'h0, v} - 8'd10;
    endfunction

    // octal number written in decimal digits, -1 when not a valid octal number
    function automatic int octal_value(input logic [15:0] n);
        int          v;
        int          scale;
        int unsigned rest;
        int unsigned d;
        v = 0;
        scale = 1;
        rest = n;
        if (n > 16'd7777)
        begin
            return -1;
        end
        repeat (4)
        begin
            d = rest % 10;
            if (d > 7)
            begin
                return -1;
            end
            v = v + d * scale;
            scale = scale * 8;
            rest = rest / 10;
        end
        return v;
    endfunction

    function automatic logic [1:0] locate_device(input logic [3:0] kind, input logic [15:0] n,
                                                 output logic [15:0] addr,
                                                 output logic [7:0] nbytes);
        int          k;
        logic [15:0] k16;
        addr = 16'h0000;
        nbytes = 8'd1;
        k = 0;
        case (kind) inside
            KIND_D:
            begin
                nbytes = 8'd2;
                if (n <= 16'd255 || (n >= 16'd1000 && n <= 16'd2499))
                begin
                    addr = D_BASE + (n << 1);
                end
                else if (n >= 16'd8000 && n <= 16'd8255)
                begin
                    addr = D_SPEC_BASE + ((n - 16'd8000) << 1);
                end
                else
                begin
                    return STAT_RANGE;
                end
            end
            KIND_X, KIND_YOUT, KIND_YPULSE:
            begin
                k = octal_value(n);
                if (k < 0)
                begin
                    return STAT_BAD;
                end
                if (kind == KIND_X && k >= coil_limit(model_sel))
                begin
                    return STAT_BAD;
                end
                k16 = k[15:0];
                case (kind)
                    KIND_X: addr = X_BASE + (k16 >> 3);
                    KIND_YOUT: addr = YOUT_BASE + (k16 >> 3);
                    default: addr = YPULSE_BASE + (k16 >> 3);
                endcase
            end
            KIND_S:
            begin
                if (n >= 16'd128)
                begin
                    return STAT_RANGE;
                end
                addr = n >> 3;
            end
            KIND_T:
            begin
                if (n > 16'd63)
                begin
                    return STAT_RANGE;
                end
                addr = T_BASE + (n << 1);
                nbytes = 8'd2;
            end
            KIND_M:
            begin
                if (n < 16'd512)
                begin
                    addr = M_BASE + (n >> 3);
                end
                else if (n >= 16'd8000 && n <= 16'd8255)
                begin
                    addr = M_SPEC_BASE + ((n - 16'd8000) >> 3);
                end
                else
                begin
                    return STAT_RANGE;
                end
            end
            KIND_C16:
            begin
                if (n >= 16'd32)
                begin
                    return STAT_RANGE;
                end
                addr = C16_BASE + (n << 1);
                nbytes = 8'd2;
            end
            KIND_C32:
            begin
                if (n <= 16'd200 || n > 16'd255)
                begin
                    return STAT_RANGE;
                end
                addr = C32_BASE + ((n - 16'd200) << 2);
                nbytes = 8'd4;
            end
            KIND_CRST:
            begin
                if (n > 16'd255)
                begin
                    return STAT_RANGE;
                end
                addr = CRST_BASE + (n >> 3);
            end
            default:
            begin
                return STAT_BAD;
            end
        endcase
        return STAT_OK;
    endfunction

    function automatic void encode_request(input logic mode, input logic [3:0] kind,
                                           input logic [15:0] n, input logic [31:0] data);
        logic [7:0]  frame[$];
        logic [15:0] addr;
        logic [7:0]  nbytes;
        logic [7:0]  data_byte;
        logic [7:0]  sum;
        logic [3:0]  reply_len;
        logic [1:0]  st;
        frame_word_t w;
        st = locate_device(kind, n, addr, nbytes);
        if (st != STAT_OK)
        begin
            w.frame_byte = CH_ERR;
            w.last_byte = 1'b1;
            w.status = st;
            w.reply_len = 4'd0;
            expected_words.push_back(w);
            return;
        end
        frame.push_back(CH_STX);
        frame.push_back(mode ? CH_WRITE : CH_READ);
        frame.push_back(ascii_hex(addr[15:12]));
        frame.push_back(ascii_hex(addr[11:8]));
        frame.push_back(ascii_hex(addr[7:4]));
        frame.push_back(ascii_hex(addr[3:0]));
        frame.push_back(ascii_hex(nbytes[7:4]));
        frame.push_back(ascii_hex(nbytes[3:0]));
        if (mode)
        begin
            for (int i = 0; i < int'(nbytes); i++)
            begin
                data_byte = data[8 * i +: 8];
                frame.push_back(ascii_hex(data_byte[7:4]));
                frame.push_back(ascii_hex(data_byte[3:0]));
            end
        end
        frame.push_back(CH_ETX);
        sum = 8'h00;
        for (int i = 1; i < frame.size(); i++)
        begin
            sum = sum + frame[i];
        end
        frame.push_back(ascii_hex(sum[7:4]));
        frame.push_back(ascii_hex(sum[3:0]));
        reply_len = mode ? 4'd0 : 4'd4 + {nbytes[2:0], 1'b0};
        for (int i = 0; i < frame.size(); i++)
        begin
            w.frame_byte = frame[i];
            w.last_byte = (i == frame.size() - 1);
            w.status = STAT_OK;
            w.reply_len = reply_len;
            expected_words.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t want;
        if (!rst_n)
        begin
            model_sel <= 2'd0;
            expected_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                model_sel <= cfg_wr_data;
            end
            if (req.valid && req.ready)
            begin
                encode_request(req.mode, req.device_kind, req.device_number, req.write_data);
            end
            if (frm.valid && frm.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word byte %h last %b status %0d reply %0d",
                             $time, frm.frame_byte, frm.last_byte, frm.status,
                             frm.expected_reply_length);
                    errors_seen = errors_seen + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (frm.frame_byte !== want.frame_byte || frm.last_byte !== want.last_byte
                        || frm.status !== want.status
                        || frm.expected_reply_length !== want.reply_len)
                    begin
                        $display("%0t: word mismatch, expected byte %h last %b status %0d reply %0d",
                                 $time, want.frame_byte, want.last_byte, want.status,
                                 want.reply_len);
                        $display("%0t:                  got byte %h last %b status %0d reply %0d",
                                 $time, frm.frame_byte, frm.last_byte, frm.status,
                                 frm.expected_reply_length);
                        errors_seen = errors_seen + 1;
                    end
                end
            end
            outstanding <= expected_words.size();
        end
        failures <= errors_seen;
    end

endmodule

// ===== sim/plc_device_command_frame_encoder_test.sv =====
// testbench top for the command frame encoder: stimulus, sink stalls and verdict
module plc_device_command_frame_encoder_test;
    import plcfe_pkg::*;

    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          RANDOM_PER_PHASE = 74;
    localparam logic [3:0]  KIND_FIRST_BAD   = 4'd10;
    localparam logic [3:0]  KIND_LAST_BAD    = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        steady;
    logic [1:0]  model_now;
    int          cycles = 0;
    int unsigned outstanding;
    int          failures;

    plcfe_in_if  req();
    plcfe_out_if frm();

    plc_device_command_frame_encoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .frm         (frm)
    );

    plcfe_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .frm         (frm),
        .outstanding (outstanding),
        .failures    (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frm.ready <= steady || ($urandom_range(99) >= 34);
    end

    function automatic int unsigned coil_cap(input logic [1:0] model);
        case (model)
            2'd0: return 6;
            2'd1: return 8;
            2'd2: return 12;
            default: return 16;
        endcase
    endfunction

    // coil index rewritten as octal digits
    function automatic int unsigned as_octal_text(input int unsigned k);
        int unsigned r;
        int unsigned scale;
        r = 0;
        scale = 1;
        repeat (4)
        begin
            r = r + (k % 8) * scale;
            scale = scale * 10;
            k = k / 8;
        end
        return r;
    endfunction

    function automatic int unsigned pick_number(input logic [3:0] kind, input logic [1:0] model);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            return $urandom_range(65535);
        end
        if (roll < 25)
        begin
            return $urandom_range(300);
        end
        case (kind) inside
            KIND_D:
            begin
                case ($urandom_range(2))
                    0: return $urandom_range(255);
                    1: return $urandom_range(2499, 1000);
                    default: return $urandom_range(8255, 8000);
                endcase
            end
            KIND_X: return as_octal_text($urandom_range(coil_cap(model) + 1));
            KIND_YOUT, KIND_YPULSE: return as_octal_text($urandom_range(4095));
            KIND_S: return $urandom_range(127);
            KIND_T: return $urandom_range(63);
            KIND_M:
            begin
                if ($urandom_range(1) == 0)
                begin
                    return $urandom_range(511);
                end
                return $urandom_range(8255, 8000);
            end
            KIND_C16: return $urandom_range(31);
            KIND_C32: return $urandom_range(255, 201);
            KIND_CRST: return $urandom_range(255);
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic send_request(input int unsigned mode, input int unsigned kind,
                                input int unsigned number, input int unsigned data);
        while (!steady && $urandom_range(99) < 34)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= mode[0];
        req.device_kind <= kind[3:0];
        req.device_number <= number[15:0];
        req.write_data <= data;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_request();
        int unsigned kind;
        if ($urandom_range(99) < 8)
        begin
            kind = $urandom_range(KIND_LAST_BAD, KIND_FIRST_BAD);
        end
        else
        begin
            kind = $urandom_range(KIND_CRST, KIND_D);
        end
        send_request($urandom_range(1), kind, pick_number(kind[3:0], model_now), $urandom());
    endtask

    task automatic wait_frames_done();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_model(input logic [1:0] model);
        wait_frames_done();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= model;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_now = model;
    endtask

    initial
    begin
        logic [1:0] phase_model[4];
        phase_model = '{2'd3, 2'd1, 2'd2, 2'd0};
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 2'd0;
        steady <= 1'b0;
        model_now = 2'd0;
        req.valid <= 1'b0;
        req.mode <= 1'b0;
        req.device_kind <= KIND_D;
        req.device_number <= 16'd0;
        req.write_data <= 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // model 0 after reset: six input coils
        send_request(0, KIND_D, 0, 32'h0);
        send_request(1, KIND_D, 2499, 32'h89ABCDEF);
        send_request(0, KIND_D, 8255, 32'h0);
        send_request(0, KIND_D, 2500, 32'h0);
        send_request(1, KIND_D, 65535, 32'hFFFFFFFF);
        send_request(0, KIND_X, 0, 32'h0);
        send_request(1, KIND_X, 5, 32'h000000FF);
        send_request(0, KIND_X, 6, 32'h0);
        send_request(0, KIND_X, 18, 32'h0);
        send_request(1, KIND_YOUT, 7777, 32'h000000A5);
        send_request(0, KIND_YPULSE, 0, 32'h0);
        send_request(0, KIND_YOUT, 7778, 32'h0);
        send_request(1, KIND_YPULSE, 7780, 32'h0);
        send_request(1, KIND_S, 127, 32'h0);
        send_request(0, KIND_S, 128, 32'h0);
        send_request(1, KIND_T, 63, 32'h0000FFFF);
        send_request(0, KIND_T, 64, 32'h0);
        send_request(0, KIND_M, 8255, 32'h0);
        send_request(0, KIND_M, 512, 32'h0);
        send_request(1, KIND_C16, 31, 32'h00001234);
        send_request(0, KIND_C32, 200, 32'h0);
        send_request(1, KIND_C32, 201, 32'hFFFFFFFF);
        send_request(0, KIND_C32, 255, 32'h0);
        send_request(1, KIND_CRST, 255, 32'h0);
        send_request(0, KIND_CRST, 256, 32'h0);
        send_request(0, KIND_FIRST_BAD, 0, 32'h0);
        send_request(1, KIND_LAST_BAD, 65535, 32'hFFFFFFFF);

        foreach (phase_model[p])
        begin
            set_model(phase_model[p]);
            steady <= (p == 1);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (p == 2 && i == RANDOM_PER_PHASE / 2)
                begin
                    wait_frames_done();
                end
                send_random_request();
            end
        end

        steady <= 1'b0;
        wait_frames_done();
        repeat (24) @(posedge clk);
        if (failures == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
